### rtl/ffpra_pkg.sv
package ffpra_pkg;

  localparam int MAX_SEGMENTS = 64;
  localparam int SEG_IDX_W    = $clog2(MAX_SEGMENTS);
  localparam int SEG_CNT_W    = $clog2(MAX_SEGMENTS + 1);
  localparam int PAGE_BYTES   = 4096;
  localparam int PAGE_SHIFT   = $clog2(PAGE_BYTES);
  localparam int WHOLE_W      = 33 - PAGE_SHIFT;

  localparam int CFG_IDX_W = 1;
  localparam logic [CFG_IDX_W-1:0] CFG_REGION_BASE  = 1'b0;
  localparam logic [CFG_IDX_W-1:0] CFG_REGION_BYTES = 1'b1;

  localparam logic [31:0] RESET_REGION_BASE  = 32'h4000_0000;
  localparam logic [31:0] RESET_REGION_BYTES = 32'h1000_0000;

  localparam logic KIND_ALLOC = 1'b0;
  localparam logic KIND_FREE  = 1'b1;

  typedef enum logic [1:0] {
    ST_OK        = 2'd0,
    ST_EXHAUSTED = 2'd1,
    ST_MAPFAIL   = 2'd2,
    ST_NOTFOUND  = 2'd3
  } status_e;

  typedef enum logic [4:0] {
    S_IDLE,
    S_SCAN_RD,
    S_SCAN_CHK,
    S_A_HIT,
    S_OPEN_RD,
    S_OPEN_WR,
    S_A_SPLIT,
    S_A_FIN,
    S_A_MISS,
    S_F_RD_R,
    S_F_CHK_R,
    S_CLOSE_RD,
    S_CLOSE_WR,
    S_F_RD_L,
    S_F_CHK_L,
    S_F_WR,
    S_DONE
  } state_e;

  typedef struct packed {
    logic        kind;
    logic [31:0] request_bytes;
    logic [31:0] release_address;
    logic        backing_ok;
  } req_t;

  typedef struct packed {
    logic [31:0] block_address;
    logic [1:0]  status;
  } rsp_t;

  typedef struct packed {
    logic [31:0] start;
    logic [31:0] pages;
    logic        used;
  } seg_t;

endpackage

### rtl/ffpra_if.sv
interface ffpra_req_if;
  logic                valid;
  logic                ready;
  ffpra_pkg::req_t     payload;
  modport source (output valid, output payload, input ready);
  modport sink   (input valid, input payload, output ready);
endinterface

interface ffpra_rsp_if;
  logic                valid;
  logic                ready;
  ffpra_pkg::rsp_t     payload;
  modport source (output valid, output payload, input ready);
  modport sink   (input valid, input payload, output ready);
endinterface

### rtl/ffpra_seg_ram.sv
module ffpra_seg_ram #(
  parameter int DEPTH = 64,
  parameter int WIDTH = 65
) (
  input  logic                     clk_i,
  input  logic                     we_i,
  input  logic [$clog2(DEPTH)-1:0] waddr_i,
  input  logic [WIDTH-1:0]         wdata_i,
  input  logic                     re_i,
  input  logic [$clog2(DEPTH)-1:0] raddr_i,
  output logic [WIDTH-1:0]         rdata_o
);

  logic [WIDTH-1:0] mem [DEPTH];

  always_ff @(posedge clk_i) begin
    if (we_i) begin
      mem[waddr_i] <= wdata_i;
    end
  end

  always_ff @(posedge clk_i) begin
    if (re_i) begin
      rdata_o <= mem[raddr_i];
    end
  end

endmodule

### rtl/first_fit_page_region_allocator_unit.sv
// Segment allocator: one item in, one item out, one item in flight at a time.
// The segment table sits in a single memory with one read and one write port,
// so an item is worked one table access after another: it scans entries up to
// the first fit or address match, moves entries when a split opens a slot or a
// merge closes one, and has setup and write-back around that. The next item is
// taken as soon as the result sits in the output register, even if it is not
// yet taken.
module first_fit_page_region_allocator_unit (
  input  logic                                  clk_i,
  input  logic                                  rst_ni,
  ffpra_req_if.sink                             req,
  ffpra_rsp_if.source                           rsp,
  input  logic                                  cfg_we_i,
  input  logic [ffpra_pkg::CFG_IDX_W-1:0]       cfg_idx_i,
  input  logic [31:0]                           cfg_data_i
);

  localparam logic [ffpra_pkg::SEG_CNT_W-1:0] MaxCnt =
    ffpra_pkg::SEG_CNT_W'(ffpra_pkg::MAX_SEGMENTS);

  ffpra_pkg::state_e state_q, state_d;

  logic [ffpra_pkg::SEG_CNT_W-1:0] cnt_q, cnt_d, idx_q, idx_d;
  logic [ffpra_pkg::SEG_IDX_W-1:0] fnd_q, fnd_d;
  ffpra_pkg::seg_t                 cur_q, cur_d;
  logic [ffpra_pkg::WHOLE_W-1:0]   whole_q, whole_d;
  logic                            kind_q, kind_d, back_q, back_d, left_q, left_d;
  logic [31:0]                     rel_q, rel_d;
  logic [31:0]                     bump_q, bump_d, base_q, base_d, bytes_q, bytes_d;
  logic [31:0]                     res_addr_q, res_addr_d;
  ffpra_pkg::status_e              res_st_q, res_st_d;
  logic                            ovalid_q, ovalid_d;
  ffpra_pkg::rsp_t                 opay_q, opay_d;

  logic                            ram_re, ram_we;
  logic [ffpra_pkg::SEG_IDX_W-1:0] ram_raddr, ram_waddr;
  ffpra_pkg::seg_t                 ram_wdata, rdata;

  logic                            in_acc;
  logic [31:0]                     need;
  logic [32:0]                     aligned;
  logic [ffpra_pkg::SEG_CNT_W-1:0] fnd_p1;
  logic                            hit, split, exhausted, scan_end, out_load;

  ffpra_seg_ram #(
    .DEPTH(ffpra_pkg::MAX_SEGMENTS),
    .WIDTH($bits(ffpra_pkg::seg_t))
  ) u_ram (
    .clk_i  (clk_i),
    .we_i   (ram_we),
    .waddr_i(ram_waddr),
    .wdata_i(ram_wdata),
    .re_i   (ram_re),
    .raddr_i(ram_raddr),
    .rdata_o(rdata)
  );

  assign req.ready = (state_q == ffpra_pkg::S_IDLE);
  assign in_acc    = req.valid && req.ready;
  assign rsp.valid   = ovalid_q;
  assign rsp.payload = opay_q;

  assign need    = 32'(whole_q) + 32'd1;
  assign aligned = {whole_q, {ffpra_pkg::PAGE_SHIFT{1'b0}}};
  assign fnd_p1  = {1'b0, fnd_q} + 1'b1;
  assign hit     = (kind_q == ffpra_pkg::KIND_ALLOC)
                   ? (!rdata.used && rdata.pages >= need)
                   : (rdata.used && rdata.start == rel_q);
  assign split    = (cur_q.pages > need) && (cnt_q < MaxCnt);
  assign scan_end = (idx_q == cnt_q);
  assign exhausted = (({1'b0, bump_q} + aligned) >= ({1'b0, base_q} + {1'b0, bytes_q}))
                     || (cnt_q >= MaxCnt);
  assign out_load = (state_q == ffpra_pkg::S_DONE) && (!ovalid_q || rsp.ready);

  // next state
  always_comb begin
    state_d = state_q;
    case (state_q)
      ffpra_pkg::S_IDLE: begin
        if (in_acc) state_d = ffpra_pkg::S_SCAN_RD;
      end
      ffpra_pkg::S_SCAN_RD: begin
        if (!scan_end) state_d = ffpra_pkg::S_SCAN_CHK;
        else if (kind_q == ffpra_pkg::KIND_ALLOC) state_d = ffpra_pkg::S_A_MISS;
        else state_d = ffpra_pkg::S_DONE;
      end
      ffpra_pkg::S_SCAN_CHK: begin
        if (!hit) state_d = ffpra_pkg::S_SCAN_RD;
        else if (kind_q == ffpra_pkg::KIND_ALLOC) state_d = ffpra_pkg::S_A_HIT;
        else state_d = ffpra_pkg::S_F_RD_R;
      end
      ffpra_pkg::S_A_HIT: state_d = split ? ffpra_pkg::S_OPEN_RD : ffpra_pkg::S_A_FIN;
      ffpra_pkg::S_OPEN_RD: begin
        state_d = (idx_q > fnd_p1) ? ffpra_pkg::S_OPEN_WR : ffpra_pkg::S_A_SPLIT;
      end
      ffpra_pkg::S_OPEN_WR: state_d = ffpra_pkg::S_OPEN_RD;
      ffpra_pkg::S_A_SPLIT: state_d = ffpra_pkg::S_A_FIN;
      ffpra_pkg::S_A_FIN:   state_d = ffpra_pkg::S_DONE;
      ffpra_pkg::S_A_MISS:  state_d = ffpra_pkg::S_DONE;
      ffpra_pkg::S_F_RD_R: begin
        state_d = (fnd_p1 < cnt_q) ? ffpra_pkg::S_F_CHK_R : ffpra_pkg::S_F_RD_L;
      end
      ffpra_pkg::S_F_CHK_R: begin
        state_d = rdata.used ? ffpra_pkg::S_F_RD_L : ffpra_pkg::S_CLOSE_RD;
      end
      ffpra_pkg::S_CLOSE_RD: begin
        if (idx_q + 1'b1 < cnt_q) state_d = ffpra_pkg::S_CLOSE_WR;
        else state_d = left_q ? ffpra_pkg::S_DONE : ffpra_pkg::S_F_RD_L;
      end
      ffpra_pkg::S_CLOSE_WR: state_d = ffpra_pkg::S_CLOSE_RD;
      ffpra_pkg::S_F_RD_L: begin
        state_d = (fnd_q != '0) ? ffpra_pkg::S_F_CHK_L : ffpra_pkg::S_F_WR;
      end
      ffpra_pkg::S_F_CHK_L: begin
        state_d = rdata.used ? ffpra_pkg::S_F_WR : ffpra_pkg::S_CLOSE_RD;
      end
      ffpra_pkg::S_F_WR: state_d = ffpra_pkg::S_DONE;
      ffpra_pkg::S_DONE: begin
        if (out_load) state_d = ffpra_pkg::S_IDLE;
      end
      default: state_d = ffpra_pkg::S_IDLE;
    endcase
  end

  // datapath and table accesses
  always_comb begin
    cnt_d      = cnt_q;
    idx_d      = idx_q;
    fnd_d      = fnd_q;
    cur_d      = cur_q;
    whole_d    = whole_q;
    kind_d     = kind_q;
    back_d     = back_q;
    rel_d      = rel_q;
    left_d     = left_q;
    bump_d     = bump_q;
    base_d     = base_q;
    bytes_d    = bytes_q;
    res_addr_d = res_addr_q;
    res_st_d   = res_st_q;
    ovalid_d   = rsp.ready ? 1'b0 : ovalid_q;
    opay_d     = opay_q;
    ram_re     = 1'b0;
    ram_raddr  = idx_q[ffpra_pkg::SEG_IDX_W-1:0];
    ram_we     = 1'b0;
    ram_waddr  = fnd_q;
    ram_wdata  = cur_q;

    if (cfg_we_i) begin
      case (cfg_idx_i)
        ffpra_pkg::CFG_REGION_BASE: begin
          base_d = cfg_data_i;
          bump_d = cfg_data_i;
        end
        ffpra_pkg::CFG_REGION_BYTES: bytes_d = cfg_data_i;
        default: ;
      endcase
    end

    case (state_q)
      ffpra_pkg::S_IDLE: begin
        if (in_acc) begin
          kind_d     = req.payload.kind;
          back_d     = req.payload.backing_ok;
          rel_d      = req.payload.release_address;
          whole_d    = ffpra_pkg::WHOLE_W'(({1'b0, req.payload.request_bytes}
                       + 33'(ffpra_pkg::PAGE_BYTES - 1)) >> ffpra_pkg::PAGE_SHIFT);
          idx_d      = '0;
          res_addr_d = '0;
          res_st_d   = ffpra_pkg::ST_NOTFOUND;
        end
      end
      ffpra_pkg::S_SCAN_RD: begin
        ram_re = !scan_end;
      end
      ffpra_pkg::S_SCAN_CHK: begin
        if (hit) begin
          fnd_d      = idx_q[ffpra_pkg::SEG_IDX_W-1:0];
          cur_d      = rdata;
          cur_d.used = 1'b0;
        end else begin
          idx_d = idx_q + 1'b1;
        end
      end
      ffpra_pkg::S_A_HIT: begin
        idx_d = cnt_q;
      end
      ffpra_pkg::S_OPEN_RD: begin
        ram_re    = (idx_q > fnd_p1);
        ram_raddr = ffpra_pkg::SEG_IDX_W'(idx_q - 1'b1);
      end
      ffpra_pkg::S_OPEN_WR: begin
        ram_we    = 1'b1;
        ram_waddr = idx_q[ffpra_pkg::SEG_IDX_W-1:0];
        ram_wdata = rdata;
        idx_d     = idx_q - 1'b1;
      end
      ffpra_pkg::S_A_SPLIT: begin
        ram_we          = 1'b1;
        ram_waddr       = fnd_p1[ffpra_pkg::SEG_IDX_W-1:0];
        ram_wdata.start = cur_q.start + 32'(need << ffpra_pkg::PAGE_SHIFT);
        ram_wdata.pages = cur_q.pages - need;
        ram_wdata.used  = 1'b0;
        cnt_d           = cnt_q + 1'b1;
        cur_d.pages     = need;
      end
      ffpra_pkg::S_A_FIN: begin
        ram_we = 1'b1;
        if (!back_q) begin
          res_st_d = ffpra_pkg::ST_MAPFAIL;
        end else begin
          if (cur_q.start == bump_q) begin
            bump_d = bump_q + 32'(cur_q.pages << ffpra_pkg::PAGE_SHIFT);
          end
          ram_wdata.used = 1'b1;
          res_addr_d     = cur_q.start;
          res_st_d       = ffpra_pkg::ST_OK;
        end
      end
      ffpra_pkg::S_A_MISS: begin
        if (exhausted) begin
          res_st_d = ffpra_pkg::ST_EXHAUSTED;
        end else begin
          ram_we          = 1'b1;
          ram_waddr       = cnt_q[ffpra_pkg::SEG_IDX_W-1:0];
          ram_wdata.start = bump_q;
          ram_wdata.pages = need;
          ram_wdata.used  = back_q;
          cnt_d           = cnt_q + 1'b1;
          if (back_q) begin
            bump_d     = bump_q + 32'(need << ffpra_pkg::PAGE_SHIFT);
            res_addr_d = bump_q;
            res_st_d   = ffpra_pkg::ST_OK;
          end else begin
            res_st_d = ffpra_pkg::ST_MAPFAIL;
          end
        end
      end
      ffpra_pkg::S_F_RD_R: begin
        res_st_d  = ffpra_pkg::ST_OK;
        ram_re    = (fnd_p1 < cnt_q);
        ram_raddr = fnd_p1[ffpra_pkg::SEG_IDX_W-1:0];
      end
      ffpra_pkg::S_F_CHK_R: begin
        if (!rdata.used) begin
          cur_d.pages = cur_q.pages + rdata.pages;
          idx_d       = fnd_p1;
          left_d      = 1'b0;
        end
      end
      ffpra_pkg::S_CLOSE_RD: begin
        ram_re    = (idx_q + 1'b1 < cnt_q);
        ram_raddr = ffpra_pkg::SEG_IDX_W'(idx_q + 1'b1);
        if (!(idx_q + 1'b1 < cnt_q)) cnt_d = cnt_q - 1'b1;
      end
      ffpra_pkg::S_CLOSE_WR: begin
        ram_we    = 1'b1;
        ram_waddr = idx_q[ffpra_pkg::SEG_IDX_W-1:0];
        ram_wdata = rdata;
        idx_d     = idx_q + 1'b1;
      end
      ffpra_pkg::S_F_RD_L: begin
        ram_re    = (fnd_q != '0);
        ram_raddr = fnd_q - 1'b1;
      end
      ffpra_pkg::S_F_CHK_L: begin
        // left neighbour free: it absorbs this segment, whose slot then closes
        if (!rdata.used) begin
          ram_we          = 1'b1;
          ram_waddr       = fnd_q - 1'b1;
          ram_wdata.start = rdata.start;
          ram_wdata.pages = rdata.pages + cur_q.pages;
          ram_wdata.used  = 1'b0;
          idx_d           = {1'b0, fnd_q};
          left_d          = 1'b1;
        end
      end
      ffpra_pkg::S_F_WR: begin
        ram_we = 1'b1;
      end
      ffpra_pkg::S_DONE: begin
        if (out_load) begin
          ovalid_d             = 1'b1;
          opay_d.block_address = res_addr_q;
          opay_d.status        = res_st_q;
        end
      end
      default: ;
    endcase
  end

  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      state_q  <= ffpra_pkg::S_IDLE;
      cnt_q    <= '0;
      bump_q   <= ffpra_pkg::RESET_REGION_BASE;
      base_q   <= ffpra_pkg::RESET_REGION_BASE;
      bytes_q  <= ffpra_pkg::RESET_REGION_BYTES;
      ovalid_q <= 1'b0;
    end else begin
      state_q  <= state_d;
      cnt_q    <= cnt_d;
      bump_q   <= bump_d;
      base_q   <= base_d;
      bytes_q  <= bytes_d;
      ovalid_q <= ovalid_d;
    end
  end

  always_ff @(posedge clk_i) begin
    idx_q      <= idx_d;
    fnd_q      <= fnd_d;
    cur_q      <= cur_d;
    whole_q    <= whole_d;
    kind_q     <= kind_d;
    back_q     <= back_d;
    rel_q      <= rel_d;
    left_q     <= left_d;
    res_addr_q <= res_addr_d;
    res_st_q   <= res_st_d;
    opay_q     <= opay_d;
  end

  a_cnt_bound: assert property (@(posedge clk_i) disable iff (!rst_ni)
    cnt_q <= MaxCnt)
    else $error("segment count beyond table size");

  a_idle_no_write: assert property (@(posedge clk_i) disable iff (!rst_ni)
    (state_q == ffpra_pkg::S_IDLE) |-> !ram_we)
    else $error("table written while idle");

  a_accept_leaves_idle: assert property (@(posedge clk_i) disable iff (!rst_ni)
    in_acc |=> (state_q != ffpra_pkg::S_IDLE))
    else $error("item accepted but sequencer stayed idle");

  a_result_from_done: assert property (@(posedge clk_i) disable iff (!rst_ni)
    $rose(ovalid_q) |-> $past(state_q) == ffpra_pkg::S_DONE)
    else $error("result raised outside completion");

endmodule

### dv/tb_first_fit_page_region_allocator_unit.sv
module tb_first_fit_page_region_allocator_unit;

  logic                            clk_i;
  logic                            rst_ni;
  logic                            cfg_we_i;
  logic [ffpra_pkg::CFG_IDX_W-1:0] cfg_idx_i;
  logic [31:0]                     cfg_data_i;

  ffpra_req_if req_ch ();
  ffpra_rsp_if rsp_ch ();

  first_fit_page_region_allocator_unit u_dut (
    .clk_i      (clk_i),
    .rst_ni     (rst_ni),
    .req        (req_ch.sink),
    .rsp        (rsp_ch.source),
    .cfg_we_i   (cfg_we_i),
    .cfg_idx_i  (cfg_idx_i),
    .cfg_data_i (cfg_data_i)
  );

  always begin
    clk_i = 1'b1;
    #5;
    clk_i = 1'b0;
    #5;
  end

  // allocator state as predicted
  logic [31:0] seg_start [ffpra_pkg::MAX_SEGMENTS];
  logic [31:0] seg_pages [ffpra_pkg::MAX_SEGMENTS];
  bit          seg_used  [ffpra_pkg::MAX_SEGMENTS];
  int          seg_cnt      = 0;
  logic [31:0] bump_addr    = ffpra_pkg::RESET_REGION_BASE;
  logic [31:0] region_base  = ffpra_pkg::RESET_REGION_BASE;
  logic [31:0] region_bytes = ffpra_pkg::RESET_REGION_BYTES;

  ffpra_pkg::req_t pending_items[$];
  ffpra_pkg::rsp_t expected_grants[$];
  logic [31:0]     live_blocks[$];

  int send_idle_pct;
  int rsp_stall_pct;
  bit hold_go     = 1'b0;
  bit hold_done   = 1'b0;
  int hold_cycles = 0;
  int mismatches  = 0;

  function automatic void close_entry(int at);
    for (int k = at; k + 1 < seg_cnt; k++) begin
      seg_start[k] = seg_start[k+1];
      seg_pages[k] = seg_pages[k+1];
      seg_used[k]  = seg_used[k+1];
    end
    seg_cnt--;
  endfunction

  function automatic ffpra_pkg::rsp_t allocate_or_release(ffpra_pkg::req_t r);
    logic [63:0]     whole;
    logic [63:0]     aligned;
    logic [31:0]     need;
    int              hit;
    ffpra_pkg::rsp_t o;
    o.block_address = '0;
    o.status        = ffpra_pkg::ST_OK;
    hit             = -1;
    if (r.kind == ffpra_pkg::KIND_ALLOC) begin
      whole   = ({32'b0, r.request_bytes} + ffpra_pkg::PAGE_BYTES - 1) / ffpra_pkg::PAGE_BYTES;
      aligned = whole * ffpra_pkg::PAGE_BYTES;
      need    = whole[31:0] + 32'd1;
      for (int i = 0; i < seg_cnt; i++) begin
        if (!seg_used[i] && seg_pages[i] >= need) begin
          hit = i;
          break;
        end
      end
      if (hit >= 0) begin
        if (seg_pages[hit] > need && seg_cnt < ffpra_pkg::MAX_SEGMENTS) begin
          for (int k = seg_cnt; k > hit + 1; k--) begin
            seg_start[k] = seg_start[k-1];
            seg_pages[k] = seg_pages[k-1];
            seg_used[k]  = seg_used[k-1];
          end
          seg_cnt++;
          seg_pages[hit+1] = seg_pages[hit] - need;
          seg_start[hit+1] = seg_start[hit] + need * ffpra_pkg::PAGE_BYTES;
          seg_used[hit+1]  = 1'b0;
          seg_pages[hit]   = need;
        end
      end else begin
        if ({32'b0, bump_addr} + aligned >= {32'b0, region_base} + {32'b0, region_bytes}
            || seg_cnt >= ffpra_pkg::MAX_SEGMENTS) begin
          o.status = ffpra_pkg::ST_EXHAUSTED;
          return o;
        end
        hit            = seg_cnt;
        seg_cnt++;
        seg_start[hit] = bump_addr;
        seg_pages[hit] = need;
        seg_used[hit]  = 1'b0;
      end
      if (!r.backing_ok) begin
        o.status = ffpra_pkg::ST_MAPFAIL;
        return o;
      end
      if (seg_start[hit] == bump_addr)
        bump_addr = bump_addr + seg_pages[hit] * ffpra_pkg::PAGE_BYTES;
      seg_used[hit]   = 1'b1;
      o.block_address = seg_start[hit];
      live_blocks.push_back(seg_start[hit]);
    end else begin
      for (int i = 0; i < seg_cnt; i++) begin
        if (seg_used[i] && seg_start[i] == r.release_address) begin
          hit = i;
          break;
        end
      end
      if (hit < 0) begin
        o.status = ffpra_pkg::ST_NOTFOUND;
        return o;
      end
      seg_used[hit] = 1'b0;
      if (hit + 1 < seg_cnt && !seg_used[hit+1]) begin
        seg_pages[hit] += seg_pages[hit+1];
        close_entry(hit + 1);
      end
      if (hit > 0 && !seg_used[hit-1]) begin
        seg_pages[hit-1] += seg_pages[hit];
        close_entry(hit);
      end
      foreach (live_blocks[j]) begin
        if (live_blocks[j] == r.release_address) begin
          live_blocks.delete(j);
          break;
        end
      end
    end
    return o;
  endfunction

  // driver
  always @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      req_ch.valid   <= 1'b0;
      req_ch.payload <= '0;
    end else begin
      if (cfg_we_i) begin
        if (cfg_idx_i == ffpra_pkg::CFG_REGION_BASE) begin
          region_base = cfg_data_i;
          bump_addr   = cfg_data_i;
        end else begin
          region_bytes = cfg_data_i;
        end
      end
      if (req_ch.valid && req_ch.ready) begin
        expected_grants.push_back(allocate_or_release(req_ch.payload));
      end
      if (!req_ch.valid || req_ch.ready) begin
        if (pending_items.size() > 0 && $urandom_range(0, 99) >= send_idle_pct) begin
          req_ch.valid   <= 1'b1;
          req_ch.payload <= pending_items.pop_front();
        end else begin
          req_ch.valid <= 1'b0;
        end
      end
    end
  end

  // monitor
  always @(posedge clk_i or negedge rst_ni) begin
    ffpra_pkg::rsp_t want;
    if (!rst_ni) begin
      rsp_ch.ready <= 1'b0;
    end else begin
      if (rsp_ch.valid && rsp_ch.ready) begin
        if (expected_grants.size() == 0) begin
          mismatches++;
          if (mismatches <= 10)
            $display("unexpected item: addr %h status %0d",
                     rsp_ch.payload.block_address, rsp_ch.payload.status);
        end else begin
          want = expected_grants.pop_front();
          if (rsp_ch.payload.block_address !== want.block_address
              || rsp_ch.payload.status !== want.status) begin
            mismatches++;
            if (mismatches <= 10)
              $display("mismatch: exp addr %h status %0d, got addr %h status %0d",
                       want.block_address, want.status,
                       rsp_ch.payload.block_address, rsp_ch.payload.status);
          end
        end
      end
      rsp_ch.ready <= !(hold_go && !hold_done) && ($urandom_range(0, 99) >= rsp_stall_pct);
    end
  end

  // long receiver hold-off
  always @(posedge clk_i) begin
    if (hold_go && !hold_done) begin
      if (hold_cycles < 400) hold_cycles <= hold_cycles + 1;
      else hold_done <= 1'b1;
    end
  end

  task automatic queue_item(ffpra_pkg::req_t r);
    while (pending_items.size() > 3) @(posedge clk_i);
    pending_items.push_back(r);
  endtask

  task automatic queue_alloc(logic [31:0] nbytes, logic backing);
    ffpra_pkg::req_t r;
    r.kind            = ffpra_pkg::KIND_ALLOC;
    r.request_bytes   = nbytes;
    r.release_address = $urandom();
    r.backing_ok      = backing;
    queue_item(r);
  endtask

  task automatic queue_free(logic [31:0] addr);
    ffpra_pkg::req_t r;
    r.kind            = ffpra_pkg::KIND_FREE;
    r.request_bytes   = $urandom();
    r.release_address = addr;
    r.backing_ok      = 1'($urandom_range(0, 1));
    queue_item(r);
  endtask

  task automatic drain();
    while (pending_items.size() > 0 || req_ch.valid || expected_grants.size() > 0)
      @(posedge clk_i);
    repeat (10) @(posedge clk_i);
  endtask

  task automatic write_reg(logic [ffpra_pkg::CFG_IDX_W-1:0] idx, logic [31:0] data);
    drain();
    cfg_we_i   <= 1'b1;
    cfg_idx_i  <= idx;
    cfg_data_i <= data;
    @(posedge clk_i);
    cfg_we_i   <= 1'b0;
  endtask

  function automatic logic [31:0] pick_live();
    if (live_blocks.size() == 0) return $urandom();
    return live_blocks[$urandom_range(0, live_blocks.size() - 1)];
  endfunction

  task automatic random_mix(int count, int free_pct);
    int roll;
    for (int n = 0; n < count; n++) begin
      roll = $urandom_range(0, 99);
      if (roll < free_pct) begin
        if ($urandom_range(0, 9) == 0) queue_free($urandom());
        else queue_free(pick_live());
      end else if ($urandom_range(0, 19) == 0) begin
        queue_alloc($urandom(), $urandom_range(0, 9) != 0);
      end else begin
        queue_alloc($urandom_range(0, 6 * ffpra_pkg::PAGE_BYTES), $urandom_range(0, 9) != 0);
      end
    end
  endtask

  initial begin
    send_idle_pct = 0;
    rsp_stall_pct = 0;
    cfg_we_i      = 1'b0;
    cfg_idx_i     = ffpra_pkg::CFG_REGION_BASE;
    cfg_data_i    = '0;
    rst_ni        = 1'b0;
    repeat (9) @(posedge clk_i);
    rst_ni <= 1'b1;
    @(posedge clk_i);

    // directed: size edges, failed mapping, merges, misses
    queue_alloc(32'd0, 1'b1);
    queue_alloc(32'd1, 1'b1);
    queue_alloc(32'd4096, 1'b1);
    queue_alloc(32'd4097, 1'b1);
    queue_alloc(32'hFFFF_FFFF, 1'b1);
    queue_alloc(32'd100, 1'b0);
    queue_alloc(32'd50, 1'b1);
    queue_alloc(32'd9000, 1'b1);
    drain();
    queue_free(live_blocks[1]);
    queue_free(live_blocks[3]);
    drain();
    queue_free(live_blocks[1]);
    queue_free(32'hFFFF_FFFF);
    queue_free(32'h0000_0000);
    queue_alloc(32'd4096, 1'b1);
    queue_alloc(32'd0, 1'b0);
    drain();
    queue_free(pick_live());
    queue_free(pick_live());

    // tiny region: exhaustion
    write_reg(ffpra_pkg::CFG_REGION_BYTES, 32'h0000_3000);
    write_reg(ffpra_pkg::CFG_REGION_BASE, 32'h4000_0000);
    queue_alloc(32'd0, 1'b1);
    queue_alloc(32'd8192, 1'b1);
    queue_alloc(32'd12288, 1'b1);
    random_mix(30, 40);

    // region empty by size, then top of address space with wrap
    write_reg(ffpra_pkg::CFG_REGION_BYTES, 32'h0000_0000);
    random_mix(15, 40);
    write_reg(ffpra_pkg::CFG_REGION_BASE, 32'hFFFF_F000);
    write_reg(ffpra_pkg::CFG_REGION_BYTES, 32'hFFFF_FFFF);
    send_idle_pct = 70;
    random_mix(40, 30);
    write_reg(ffpra_pkg::CFG_REGION_BASE, 32'h0000_0000);
    random_mix(30, 30);

    // fill the table, then split with it full
    write_reg(ffpra_pkg::CFG_REGION_BASE, 32'h1000_0000);
    write_reg(ffpra_pkg::CFG_REGION_BYTES, ffpra_pkg::RESET_REGION_BYTES);
    send_idle_pct = 0;
    rsp_stall_pct = 70;
    for (int n = 0; n < 70; n++)
      queue_alloc($urandom_range(0, 5 * ffpra_pkg::PAGE_BYTES), 1'b1);
    random_mix(60, 50);

    // long receiver hold-off while items keep coming
    rsp_stall_pct = 0;
    hold_go       = 1'b1;
    random_mix(40, 40);
    drain();

    send_idle_pct = 19;
    rsp_stall_pct = 19;
    random_mix(120, 35);
    send_idle_pct = 0;
    rsp_stall_pct = 0;
    random_mix(25, 40);

    drain();
    repeat (300) @(posedge clk_i);
    if (mismatches == 0 && expected_grants.size() == 0) begin
      $display("ALL CHECKS PASSED");
    end else begin
      $display("CHECKS FAILED");
    end
    $finish;
  end

  initial begin
    #30_000_000;
    $display("CHECKS FAILED");
    $finish;
  end

endmodule

### sim.f
rtl/ffpra_pkg.sv
rtl/ffpra_if.sv
rtl/ffpra_seg_ram.sv
rtl/first_fit_page_region_allocator_unit.sv
dv/tb_first_fit_page_region_allocator_unit.sv
